@@ hw/rtl/wmfd_pkg.sv @@
// Shared types, codes and fixed-point helpers for the weight matrix layer.
package wmfd_pkg;

  localparam int DATA_W = 32;
  localparam int RATE_W = 21;
  localparam int NODE_W = 4;
  localparam int ROW_W = 4;
  localparam int COL_W = 6;
  localparam int MAX_REPORT = 16;
  localparam logic [RATE_W-1:0] RATE_RESET = 21'd6554;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_FORWARD = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_LEARN   = 2'd3
  } kind_t;

  typedef struct packed {
    logic       active;
    logic       learn;
    logic [31:0] value;
  } cell_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) r = 32'sh7fffffff;
    else if (v < -65'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/wmfd_cell.sv @@
// One output row: its weight column memory, accumulator and error register.
module wmfd_cell
  import wmfd_pkg::*;
#(
  parameter int HIDDEN_NODES = 64,
  parameter int HID_IDX_W = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctl_t             ctl_in,
  input  logic [HID_IDX_W-1:0]  col_in,
  output cell_ctl_t             ctl_out,
  output logic [HID_IDX_W-1:0]  col_out,
  input  logic                  wr_en,
  input  logic                  err_en,
  input  logic [HID_IDX_W-1:0]  wr_col,
  input  logic [31:0]           wr_data,
  input  logic [RATE_W-1:0]     learn_rate,
  input  logic                  acc_clear,
  output logic signed [31:0]    acc
);

  logic signed [31:0] weights [HIDDEN_NODES];
  logic signed [31:0] err;
  logic signed [31:0] rate_err;
  logic signed [31:0] w_rd;
  cell_ctl_t          s1;
  logic [HID_IDX_W-1:0] s1_col;
  logic signed [31:0] prod_q;
  cell_ctl_t          s2;
  logic [HID_IDX_W-1:0] s2_col;
  logic signed [31:0] w2;
  logic signed [63:0] p;
  logic signed [64:0] sum;

  always_ff @(posedge clk) begin
    rate_err <= sat32(65'(($signed({1'b0, learn_rate}) * err) >>> 16));
    if (err_en) err <= wr_data;
  end

  // stage 1: read weight
  always_ff @(posedge clk) begin
    w_rd <= weights[col_in];
    s1_col <= col_in;
    if (rst) s1 <= '0;
    else s1 <= ctl_in;
  end

  // stage 2: multiply
  always_comb begin
    if (s1.learn) p = 64'(rate_err) * 64'($signed(s1.value));
    else p = 64'(w_rd) * 64'($signed(s1.value));
  end

  always_ff @(posedge clk) begin
    prod_q <= sat32(65'(p >>> 16));
    w2 <= w_rd;
    s2_col <= s1_col;
    if (rst) s2 <= '0;
    else s2 <= s1;
  end

  // stage 3: update
  always_comb begin
    if (s2.learn) sum = 65'(w2) + 65'(prod_q);
    else sum = 65'(acc) + 65'(prod_q);
  end

  always_ff @(posedge clk) begin
    if (wr_en) weights[wr_col] <= wr_data;
    else if (s2.active && s2.learn) weights[s2_col] <= sat32(sum);
  end

  always_ff @(posedge clk) begin
    if (rst || acc_clear) acc <= '0;
    else if (s2.active && !s2.learn) acc <= sat32(sum);
  end

  assign ctl_out = s2;
  assign col_out = s2_col;

endmodule

@@ hw/rtl/weight_matrix_forward_and_delta.sv @@
// Top level of the weight matrix forward and delta-rule layer.
// A chain of OUT_NODES cells, one per output row; a forward or learn request
// enters cell 0 and passes through each cell's s1 and s2 registers in turn,
// so each cell updates after the one before it. Every request, weight and
// error writes included, holds the input stalled for a run timed by the run
// counter, and the next request is taken only once that run is over. A
// forward request with last then reports min(OUT_NODES,16) results, one per
// cycle as the output takes them, and the input stays stalled until the
// final result is taken.
module weight_matrix_forward_and_delta
  import wmfd_pkg::*;
#(
  parameter int OUT_NODES = 16,
  parameter int HIDDEN_NODES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RATE_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          kind,
  input  logic [ROW_W-1:0]    out_index,
  input  logic [COL_W-1:0]    hid_index,
  input  logic signed [31:0]  value,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [NODE_W-1:0]   node,
  output logic signed [31:0]  activation,
  output logic                final_res
);

  localparam int HID_IDX_W = (HIDDEN_NODES > 1) ? $clog2(HIDDEN_NODES) : 1;
  localparam int ACC_W = (OUT_NODES > 1) ? $clog2(OUT_NODES) : 1;
  localparam int N_REP = (OUT_NODES < MAX_REPORT) ? OUT_NODES : MAX_REPORT;
  localparam int REP_W = $clog2(MAX_REPORT + 1);
  localparam int CYC = 3 * OUT_NODES + 2;
  localparam int CYC_W = $clog2(CYC + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_REPORT} state_t;

  state_t               state;
  logic [RATE_W-1:0]    learn_rate;
  logic [CYC_W-1:0]     cnt;
  logic                 rep_pending;
  logic [REP_W-1:0]     rep_idx;
  cell_ctl_t            ctl [OUT_NODES+1];
  logic [HID_IDX_W-1:0] col [OUT_NODES+1];
  logic signed [31:0]   accs [OUT_NODES];
  logic                 acc_clear;
  logic                 accept;
  logic                 col_ok;
  logic                 row_ok;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign col_ok = (32'(hid_index) < HIDDEN_NODES);
  assign row_ok = (32'(out_index) < OUT_NODES);
  assign acc_clear = (state == S_REPORT) && out_valid && !out_stall && final_res;

  always_ff @(posedge clk) begin
    if (rst) learn_rate <= RATE_RESET;
    else if (cfg_we) learn_rate <= cfg_data;
  end

  assign ctl[0].active = accept && col_ok &&
                         (kind == KIND_FORWARD || kind == KIND_LEARN);
  assign ctl[0].learn = (kind == KIND_LEARN);
  assign ctl[0].value = value;
  assign col[0] = HID_IDX_W'(hid_index);

  for (genvar g = 0; g < OUT_NODES; g++) begin : g_cell
    wmfd_cell #(.HIDDEN_NODES(HIDDEN_NODES), .HID_IDX_W(HID_IDX_W)) u_cell (
      .clk(clk), .rst(rst),
      .ctl_in(ctl[g]), .col_in(col[g]),
      .ctl_out(ctl[g+1]), .col_out(col[g+1]),
      .wr_en(accept && kind == KIND_WRITE && col_ok && row_ok &&
             32'(out_index) == g),
      .err_en(accept && kind == KIND_ERROR && row_ok && 32'(out_index) == g),
      .wr_col(HID_IDX_W'(hid_index)), .wr_data(value),
      .learn_rate(learn_rate), .acc_clear(acc_clear), .acc(accs[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      rep_pending <= 1'b0;
      rep_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
            cnt <= '0;
            rep_pending <= (kind == KIND_FORWARD) && last;
          end
        end
        S_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CYC_W'(CYC)) begin
            rep_idx <= '0;
            state <= rep_pending ? S_REPORT : S_IDLE;
          end
        end
        S_REPORT: begin
          if (!out_stall) begin
            rep_idx <= rep_idx + 1'b1;
            if (final_res) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid = (state == S_REPORT);
  assign node = rep_idx[NODE_W-1:0];
  assign activation = accs[ACC_W'(rep_idx)];
  assign final_res = (32'(rep_idx) == N_REP - 1);

endmodule

@@ tb/weight_matrix_forward_and_delta_check.sv @@
// Request and result monitor with predictor for the weight matrix layer.
module weight_matrix_forward_and_delta_check
  import wmfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RATE_W-1:0]   cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          kind,
  input  logic [ROW_W-1:0]    out_index,
  input  logic [COL_W-1:0]    hid_index,
  input  logic signed [31:0]  value,
  input  logic                last,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [NODE_W-1:0]   node,
  input  logic signed [31:0]  activation,
  input  logic                final_res,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 16;
  localparam int COLS = 64;

  typedef struct {
    logic [NODE_W-1:0]  node;
    logic signed [31:0] activation;
    logic               final_res;
  } node_report_t;

  node_report_t       report_q[$];
  logic signed [31:0] wgt[ROWS*COLS];
  logic signed [31:0] acc[ROWS];
  logic signed [31:0] err[ROWS];
  logic [RATE_W-1:0]  rate;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q16_mul(longint a, longint b);
    longint p;
    p = (a * b) >>> 16;
    return clamp32(p);
  endfunction

  always @(posedge clk) begin
    node_report_t       r;
    node_report_t       e;
    logic signed [31:0] re;
    logic signed [31:0] d;
    int                 k;
    if (rst) begin
      rate = RATE_RESET;
      for (int o = 0; o < ROWS; o++) acc[o] = '0;
    end else begin
      if (cfg_we) rate = cfg_data;
      if (in_valid && !in_stall) begin
        case (kind_t'(kind))
          KIND_WRITE: wgt[out_index*COLS + hid_index] = value;
          KIND_ERROR: err[out_index] = value;
          KIND_LEARN: begin
            for (int o = 0; o < ROWS; o++) begin
              re = q16_mul(longint'(rate), longint'(err[o]));
              d = q16_mul(longint'(re), longint'(value));
              k = o*COLS + hid_index;
              wgt[k] = clamp32(longint'(wgt[k]) + longint'(d));
            end
          end
          KIND_FORWARD: begin
            for (int o = 0; o < ROWS; o++)
              acc[o] = clamp32(longint'(acc[o]) +
                               longint'(q16_mul(longint'(value),
                                                longint'(wgt[o*COLS + hid_index]))));
            if (last) begin
              for (int o = 0; o < ROWS; o++) begin
                e.node = o[NODE_W-1:0];
                e.activation = acc[o];
                e.final_res = (o == ROWS-1);
                report_q.push_back(e);
                acc[o] = '0;
              end
            end
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        r.node = node;
        r.activation = activation;
        r.final_res = final_res;
        results_seen++;
        if (report_q.size() == 0) begin
          $error("unexpected result node=%0d activation=%0d", node, activation);
          fail_count++;
        end else begin
          e = report_q.pop_front();
          if (r.node !== e.node) begin
            $error("node: expected %0d, actual %0d", e.node, r.node);
            fail_count++;
          end
          if (r.activation !== e.activation) begin
            $error("activation: expected %0d, actual %0d", e.activation, r.activation);
            fail_count++;
          end
          if (r.final_res !== e.final_res) begin
            $error("final_res: expected %0d, actual %0d", e.final_res, r.final_res);
            fail_count++;
          end
        end
      end
    end
    pending = report_q.size();
  end

endmodule

@@ tb/weight_matrix_forward_and_delta_test.sv @@
// Stimulus and verdict for the weight matrix forward and delta-rule layer.
module weight_matrix_forward_and_delta_test;
  import wmfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [RATE_W-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         kind = KIND_WRITE;
  logic [ROW_W-1:0]   out_index = '0;
  logic [COL_W-1:0]   hid_index = '0;
  logic signed [31:0] value = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [NODE_W-1:0]  node;
  logic signed [31:0] activation;
  logic               final_res;
  int                 fail_count;
  int                 pending;
  int                 results_seen;

  bit                 calm = 0;
  bit                 hold_req = 0;
  bit                 held = 0;
  bit                 rate_moved = 0;
  bit                 written[16][64];
  int                 ready_cols[$];
  int                 n_forward = 0;
  int                 n_learn = 0;
  int                 n_other = 0;

  weight_matrix_forward_and_delta u_dut (
    .clk, .rst, .cfg_we, .cfg_data, .in_valid, .in_stall, .kind, .out_index,
    .hid_index, .value, .last, .out_valid, .out_stall, .node, .activation, .final_res
  );

  weight_matrix_forward_and_delta_check u_check (
    .clk, .rst, .cfg_we, .cfg_data, .in_valid, .in_stall, .kind, .out_index,
    .hid_index, .value, .last, .out_valid, .out_stall, .node, .activation, .final_res,
    .fail_count, .pending, .results_seen
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        out_stall = 1'b0;
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3, 4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_col();
    return ready_cols[$urandom_range(0, ready_cols.size()-1)];
  endfunction

  task automatic send(kind_t k, int row, int col, logic signed [31:0] v, int lst);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    kind = k;
    out_index = ROW_W'(row);
    hid_index = COL_W'(col);
    value = v;
    last = lst[0];
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    if (k == KIND_WRITE) begin
      bit full;
      written[row][col] = 1;
      full = 1;
      for (int o = 0; o < 16; o++) full &= written[o][col];
      if (full && !(col inside {ready_cols})) ready_cols.push_back(col);
    end
    if (k == KIND_FORWARD) n_forward++;
    else if (k == KIND_LEARN) n_learn++;
    else n_other++;
  endtask

  task automatic set_rate(logic [RATE_W-1:0] r);
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_data = r;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic forward_vector(int len);
    for (int i = 0; i < len; i++)
      send(KIND_FORWARD, $urandom_range(0, 15), pick_col(), pick_value(), int'(i == len-1));
  endtask

  initial begin
    int cols[5] = '{0, 21, 42, 63, 7};
    int wait_cycles;
    repeat (3) @(negedge clk);
    rst = 1'b0;
    foreach (cols[c])
      for (int o = 0; o < 16; o++)
        send(KIND_WRITE, o, cols[c], pick_value(), $urandom_range(0, 1));
    for (int o = 0; o < 16; o++)
      send(KIND_ERROR, o, $urandom_range(0, 63), pick_value(), $urandom_range(0, 1));

    send(KIND_FORWARD, 0, 0, 32'sh7fffffff, 1);
    send(KIND_FORWARD, 15, 63, 32'sh80000000, 1);
    send(KIND_FORWARD, 3, 21, 32'sd0, 0);
    send(KIND_FORWARD, 3, 42, 32'sh00010000, 1);
    send(KIND_WRITE, 15, 63, 32'sh7fffffff, 1);
    send(KIND_WRITE, 0, 0, 32'sh80000000, 0);
    send(KIND_ERROR, 15, 0, 32'sh7fffffff, 1);
    send(KIND_ERROR, 0, 63, 32'sh80000000, 0);
    send(KIND_LEARN, 5, 63, 32'sh7fffffff, 1);
    send(KIND_LEARN, 9, 0, 32'sh80000000, 0);
    send(KIND_FORWARD, 0, 63, 32'sh7fffffff, 0);
    send(KIND_FORWARD, 0, 0, 32'sh7fffffff, 1);
    set_rate(21'd1048576);
    send(KIND_LEARN, 0, 21, 32'sh00010000, 0);
    send(KIND_FORWARD, 0, 21, 32'sh00010000, 1);
    set_rate(21'd0);
    send(KIND_LEARN, 0, 42, 32'sh7fffffff, 1);
    send(KIND_FORWARD, 0, 42, 32'sh00010000, 1);
    for (int o = 0; o < 16; o++)
      send(KIND_ERROR, o, 0, $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000, 0);
    set_rate(RATE_RESET);

    for (int i = 0; i < 240; ) begin
      if (i >= 90 && !held) begin
        held = 1;
        hold_req = 1;
        forward_vector(2);
        forward_vector(3);
        i += 5;
      end
      if (i >= 120 && !rate_moved) begin
        rate_moved = 1;
        set_rate(RATE_W'($urandom_range(0, 1048576)));
        i += 5;
      end
      if (i >= 200) calm = 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          int len = $urandom_range(1, 6);
          forward_vector(len);
          i += len;
        end
        4, 5: begin
          send(KIND_LEARN, $urandom_range(0, 15), pick_col(), pick_value(), $urandom_range(0, 1));
          i++;
        end
        6, 7: begin
          send(KIND_WRITE, $urandom_range(0, 15), $urandom_range(0, 63), pick_value(),
               $urandom_range(0, 1));
          i++;
        end
        8: begin
          send(KIND_ERROR, $urandom_range(0, 15), $urandom_range(0, 63), pick_value(),
               $urandom_range(0, 1));
          i++;
        end
        default: begin
          send(KIND_FORWARD, $urandom_range(0, 15), pick_col(), pick_value(), 0);
          i++;
        end
      endcase
    end
    forward_vector(1);

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (60) @(negedge clk);
    $display("Run covered %0d forward, %0d learn and %0d write or error requests;",
             n_forward, n_learn, n_other);
    $display("%0d node results checked across several learning rates.", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ weight_matrix_forward_and_delta.f @@
hw/rtl/wmfd_pkg.sv
hw/rtl/wmfd_cell.sv
hw/rtl/weight_matrix_forward_and_delta.sv
tb/weight_matrix_forward_and_delta_check.sv
tb/weight_matrix_forward_and_delta_test.sv
